@@ hdl/litc_pkg.sv @@
// Shared constants, register indexes and controller/datapath interface types.
`timescale 1ns / 1ps

package litc_pkg;

  localparam int COUNT_WIDTH   = 24;
  localparam int VEC_FRAC_BITS = 20;

  localparam int COEF_W     = 32;
  localparam int COEF_FRAC  = 20;
  localparam int VEC_W      = 24;
  localparam int TOTAL_FRAC = COEF_FRAC + VEC_FRAC_BITS;
  localparam int KEEP_FRAC  = 24;
  localparam int DROP_BITS  = TOTAL_FRAC - KEEP_FRAC;

  // index value keeps the integer LSB plus all fraction bits
  localparam int H_W     = TOTAL_FRAC + 1;
  localparam int RES_W   = KEEP_FRAC + 1;
  localparam int MUL_A_W = COEF_W;
  localparam int MUL_B_W = RES_W;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int SCORE_W = 2 * KEEP_FRAC;
  localparam int TOL_W   = 50;

  localparam int CNT_OUT_W  = 24;
  localparam int N_COEF     = 9;
  localparam int COEF_IDX_W = 4;
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 32;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_ADDR_W-1:0] REG_COEF_PAIR_0 = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_COEF_PAIR_1 = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_COEF_PAIR_2 = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_COEF_PAIR_3 = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_COEF_FINAL  = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_TOL_SQ      = 3'd5;

  typedef struct packed {
    logic       load_item;
    logic       mul_coef;
    logic       mul_sq;
    logic       h_load;
    logic       h_add;
    logic       res_load;
    logic       score_add;
    logic       finish;
    logic [1:0] row;
    logic [1:0] col;
  } litc_cmd_t;

  typedef struct packed {
    logic out_busy;
  } litc_sts_t;

endpackage

@@ hdl/lattice_index_tolerance_counter.sv @@
// Top level: hkl indexing score with a set-based saturating hit counter.
// The result item is registered after all three rows, once the output register is free.
// A new item is taken only after the last one is done; nine coefficient products and
//   three squares go one at a time through a single 32x25 multiplier.
// The output register frees the input side while a result waits to be taken.
// Reset (rst_n, synchronous): clears sequencer, counter, output valid and cfg registers.
`timescale 1ns / 1ps

module lattice_index_tolerance_counter
  import litc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // gx[23:0], gy[47:24], gz[71:48]
  input  logic                  in_tlast,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // hit[0], count[24:1], zero pad
  output logic                  out_tlast
);

  litc_cmd_t cmd;
  litc_sts_t sts;

  litc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  litc_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

@@ hdl/litc_ctrl.sv @@
// Sequencer that walks the matrix rows and columns through the shared multiplier.
`timescale 1ns / 1ps

module litc_ctrl
  import litc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  litc_sts_t sts,
  output litc_cmd_t cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_ACC  = 3'd2;
  localparam logic [2:0] ST_RES  = 3'd3;
  localparam logic [2:0] ST_SQR  = 3'd4;
  localparam logic [2:0] ST_SUM  = 3'd5;
  localparam logic [2:0] ST_FIN  = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic [1:0] row_r, row_nxt;
  logic [1:0] col_r, col_nxt;

  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    cmd       = '0;
    cmd.row   = row_r;
    cmd.col   = col_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load_item = 1'b1;
          row_nxt       = 2'd0;
          col_nxt       = 2'd0;
          state_nxt     = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul_coef = 1'b1;
        // the product of the previous column lands in the accumulator
        cmd.h_load   = (col_r == 2'd1);
        cmd.h_add    = (col_r == 2'd2);
        if (col_r == 2'd2) begin
          state_nxt = ST_ACC;
        end else begin
          col_nxt = col_r + 2'd1;
        end
      end
      ST_ACC: begin
        cmd.h_add = 1'b1;
        state_nxt = ST_RES;
      end
      ST_RES: begin
        cmd.res_load = 1'b1;
        state_nxt    = ST_SQR;
      end
      ST_SQR: begin
        cmd.mul_sq = 1'b1;
        state_nxt  = ST_SUM;
      end
      ST_SUM: begin
        cmd.score_add = 1'b1;
        if (row_r == 2'd2) begin
          state_nxt = ST_FIN;
        end else begin
          row_nxt   = row_r + 2'd1;
          col_nxt   = 2'd0;
          state_nxt = ST_MUL;
        end
      end
      ST_FIN: begin
        // hold until the output register is free
        if (!sts.out_busy) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      row_r   <= '0;
      col_r   <= '0;
    end else begin
      state_r <= state_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
    end
  end

endmodule

@@ hdl/litc_datapath.sv @@
// Coefficient registers, shared multiplier, residual, score and set counter.
`timescale 1ns / 1ps

module litc_datapath
  import litc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tlast,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast,
  input  litc_cmd_t             cmd,
  output litc_sts_t             sts
);

  logic [COEF_W-1:0]         mat_r [N_COEF];
  logic [TOL_W-1:0]          tol_r;
  logic signed [VEC_W-1:0]   g_r [3];
  logic                      last_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic [H_W-1:0]            h_r;
  logic signed [RES_W-1:0]   t_r;
  logic [SCORE_W-1:0]        score_r;
  logic [COUNT_WIDTH-1:0]    cnt_r;
  logic                      out_valid_r;
  logic                      out_hit_r;
  logic [CNT_OUT_W-1:0]      out_count_r;
  logic                      out_last_r;

  logic [COEF_IDX_W-1:0]     coef_idx;
  logic [COEF_W-1:0]         coef_sel;
  logic signed [VEC_W-1:0]   g_sel;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic [TOTAL_FRAC-1:0]     low;
  logic                      tie;
  logic [TOTAL_FRAC:0]       fh;
  logic [RES_W-1:0]          t_nxt;
  logic                      hit;
  logic [COUNT_WIDTH-1:0]    cnt_inc;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < N_COEF; i++) begin
        mat_r[i] <= '0;
      end
      tol_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_COEF_PAIR_0: begin
          mat_r[0] <= cfg_wdata[31:0];
          mat_r[1] <= cfg_wdata[63:32];
        end
        REG_COEF_PAIR_1: begin
          mat_r[2] <= cfg_wdata[31:0];
          mat_r[3] <= cfg_wdata[63:32];
        end
        REG_COEF_PAIR_2: begin
          mat_r[4] <= cfg_wdata[31:0];
          mat_r[5] <= cfg_wdata[63:32];
        end
        REG_COEF_PAIR_3: begin
          mat_r[6] <= cfg_wdata[31:0];
          mat_r[7] <= cfg_wdata[63:32];
        end
        REG_COEF_FINAL: begin
          mat_r[8] <= cfg_wdata[31:0];
        end
        REG_TOL_SQ: begin
          tol_r <= cfg_wdata[TOL_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // operand selection for the shared multiplier
  assign coef_idx = COEF_IDX_W'(cmd.row) * COEF_IDX_W'(3) + COEF_IDX_W'(cmd.col);
  assign coef_sel = (coef_idx < COEF_IDX_W'(N_COEF)) ? mat_r[coef_idx] : '0;

  always_comb begin
    unique case (cmd.col)
      2'd0:    g_sel = g_r[0];
      2'd1:    g_sel = g_r[1];
      2'd2:    g_sel = g_r[2];
      default: g_sel = '0;
    endcase
  end

  always_comb begin
    if (cmd.mul_sq) begin
      mul_a = MUL_A_W'(t_r);
      mul_b = t_r;
    end else begin
      mul_a = signed'(coef_sel);
      mul_b = MUL_B_W'(g_sel);
    end
  end

  assign prod = mul_a * mul_b;

  // distance to the nearest integer, ties to even, then cut to KEEP_FRAC bits
  assign low = h_r[TOTAL_FRAC-1:0];
  assign tie = (low == {1'b1, {(TOTAL_FRAC-1){1'b0}}});

  always_comb begin
    if (tie) begin
      fh = h_r[TOTAL_FRAC] ? '0 : {1'b1, {TOTAL_FRAC{1'b0}}};
    end else begin
      fh = {1'b0, ~low[TOTAL_FRAC-1], low[TOTAL_FRAC-2:0]};
    end
  end

  assign t_nxt = RES_W'(fh[TOTAL_FRAC:DROP_BITS]) - RES_W'(1 << (KEEP_FRAC - 1));

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      g_r[0] <= in_tdata[VEC_W-1:0];
      g_r[1] <= in_tdata[2*VEC_W-1:VEC_W];
      g_r[2] <= in_tdata[3*VEC_W-1:2*VEC_W];
      last_r <= in_tlast;
    end
    if (cmd.mul_coef || cmd.mul_sq) begin
      prod_r <= prod;
    end
    if (cmd.h_load) begin
      h_r <= prod_r[H_W-1:0];
    end else if (cmd.h_add) begin
      h_r <= h_r + prod_r[H_W-1:0];
    end
    if (cmd.res_load) begin
      t_r <= signed'(t_nxt);
    end
    if (cmd.load_item) begin
      score_r <= '0;
    end else if (cmd.score_add) begin
      score_r <= score_r + prod_r[SCORE_W-1:0];
    end
  end

  // score test and saturating set counter
  assign hit     = {{(TOL_W-SCORE_W){1'b0}}, score_r} < tol_r;
  assign cnt_inc = (hit && (cnt_r != '1)) ? cnt_r + COUNT_WIDTH'(1) : cnt_r;

  assign sts.out_busy = out_valid_r && !out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      cnt_r       <= last_r ? '0 : cnt_inc;
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_hit_r   <= hit;
      out_count_r <= CNT_OUT_W'(cnt_inc);
      out_last_r  <= last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W-CNT_OUT_W-1){1'b0}}, out_count_r, out_hit_r};
  assign out_tlast  = out_last_r;

endmodule

@@ hdl/litc_checker.sv @@
// Port-level checks for the indexing counter, bound to the top level.
`timescale 1ns / 1ps

module litc_checker
  import litc_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  out_tlast
);

  // a stalled result item stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result item dropped while stalled");

  // one item in flight: no new item right after one is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken again while busy");

  // a new result only appears at the end of an item's work
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(in_tready))
    else $error("result item without work");

  // a result offered right after the end of a set counts from zero
  a_first_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast
      |=> !out_tvalid || (out_tdata[24:1] == {23'd0, out_tdata[0]}))
    else $error("count not cleared after end of set");

endmodule

bind lattice_index_tolerance_counter litc_checker u_litc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
